### hdl/kscu_pkg.sv
// Shared types and constants for the keyword substitution cipher unit.
// Used by the front classifier, the item queue, the back engine and the top level.
package kscu_pkg;

  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned MODE_W      = 2;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_KEY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEC = 2'd2;

  // ASCII letter bounds
  localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;

  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_ENC = 2'd1,
    OP_DEC = 2'd2
  } op_kind_e;

  // classified item as carried through the queue
  typedef struct packed {
    op_kind_e              kind;
    logic [CHAR_W-1:0]     ch;
    logic                  is_letter;
    logic                  lower;
    logic [LETTER_W-1:0]   idx;
    logic                  last;
  } op_t;

endpackage

### hdl/kscu_front.sv
// Front classifier: accepts input words, decodes mode and letter class.
// Depends on kscu_pkg; feeds kscu_fifo.
module kscu_front (
  input  logic                          in_valid_i,
  input  logic [kscu_pkg::MODE_W-1:0]   mode_i,
  input  logic [kscu_pkg::CHAR_W-1:0]   char_in_i,
  input  logic                          keyword_last_i,
  input  logic                          fifo_full_i,
  output logic                          in_stall_o,
  output logic                          push_o,
  output kscu_pkg::op_t                 op_o
);
  import kscu_pkg::*;

  logic              is_upper;
  logic              is_lower;
  logic [CHAR_W-1:0] offset;

  // stall while the queue has no room
  assign in_stall_o = fifo_full_i;

  // detect ASCII letters and derive the letter index
  assign is_upper = (char_in_i >= CHAR_UP_A) && (char_in_i <= CHAR_UP_Z);
  assign is_lower = (char_in_i >= CHAR_LO_A) && (char_in_i <= CHAR_LO_Z);
  assign offset   = char_in_i - (is_lower ? CHAR_LO_A : CHAR_UP_A);

  // build the queue entry
  always_comb begin
    op_o.ch        = char_in_i;
    op_o.is_letter = is_upper | is_lower;
    op_o.lower     = is_lower;
    op_o.idx       = offset[LETTER_W-1:0];
    op_o.last      = keyword_last_i;
    case (mode_i)
      MODE_KEY: op_o.kind = OP_KEY;
      MODE_ENC: op_o.kind = OP_ENC;
      MODE_DEC: op_o.kind = OP_DEC;
      default:  op_o.kind = OP_KEY;
    endcase
  end

  // drop the unused mode code here
  assign push_o = in_valid_i && !fifo_full_i &&
                  ((mode_i == MODE_KEY) || (mode_i == MODE_ENC) || (mode_i == MODE_DEC));

endmodule

### hdl/kscu_fifo.sv
// Short queue of classified words between front and back.
// Depends on kscu_pkg for op_t and the queue depth.
module kscu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kscu_pkg::op_t op_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output kscu_pkg::op_t op_o
);
  import kscu_pkg::*;

  op_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

### hdl/kscu_back.sv
// Back engine: builds the alphabet, runs the Z..A fill and maps text words.
// Depends on kscu_pkg; pops from kscu_fifo and drives the output register.
module kscu_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fifo_valid_i,
  input  kscu_pkg::op_t               op_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kscu_pkg::CHAR_W-1:0] char_out_o
);
  import kscu_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_FILL = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  logic [LETTER_W-1:0]    fill_k_q, fill_k_d;
  logic [NUM_LETTERS-1:0] used_q, used_d, used_eff;
  logic [LETTER_W-1:0]    placed_q, placed_d, placed_eff;
  logic                   complete_q, complete_d;

  logic [LETTER_W-1:0]    cipher_mem [NUM_LETTERS];
  logic [LETTER_W-1:0]    plain_mem  [NUM_LETTERS];

  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      ch_q;
  logic                   lower_q;
  logic                   hit_q;
  logic [LETTER_W-1:0]    rd_q;

  logic                   out_free;
  logic                   key_pop;
  logic                   text_pop;
  logic                   filling;
  logic                   place_req;
  logic [LETTER_W-1:0]    place_idx;
  logic                   can_place;
  logic                   hit;

  // pop control: keywords need no output slot, text needs one
  assign filling  = (state_q == ST_FILL);
  assign out_free = !out_valid_q || !out_stall_i;
  assign key_pop  = fifo_valid_i && !filling && (op_i.kind == OP_KEY);
  assign text_pop = fifo_valid_i && !filling && (op_i.kind != OP_KEY) && out_free;
  assign pop_o    = key_pop || text_pop;

  // a keyword after completion starts a fresh alphabet
  assign used_eff   = (key_pop && complete_q) ? '0 : used_q;
  assign placed_eff = (key_pop && complete_q) ? '0 : placed_q;

  // select the letter to place: fill counter or keyword letter
  assign place_idx = filling ? fill_k_q : op_i.idx;
  assign place_req = filling || (key_pop && op_i.is_letter);
  assign can_place = place_req && !used_eff[place_idx] &&
                     (placed_eff < LETTER_W'(NUM_LETTERS));

  // text hit: encrypt needs a full alphabet, decrypt a placed letter
  assign hit = op_i.is_letter &&
               ((op_i.kind == OP_ENC) ? complete_q : used_q[op_i.idx]);

  // next state of alphabet builder
  always_comb begin
    state_d    = state_q;
    fill_k_d   = fill_k_q;
    used_d     = used_eff;
    placed_d   = placed_eff;
    complete_d = complete_q;
    if (can_place) begin
      used_d[place_idx] = 1'b1;
      placed_d          = placed_eff + 1'b1;
    end
    case (state_q)
      ST_RUN: begin
        if (key_pop) begin
          complete_d = 1'b0;
          if (op_i.last) begin
            state_d  = ST_FILL;
            fill_k_d = LETTER_W'(NUM_LETTERS - 1);
          end
        end
      end
      ST_FILL: begin
        if (fill_k_q == '0) begin
          state_d    = ST_RUN;
          complete_d = 1'b1;
        end else begin
          fill_k_d = fill_k_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // hold or drop the output word
  always_comb begin
    out_valid_d = out_valid_q;
    if (text_pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      fill_k_q    <= '0;
      used_q      <= '0;
      placed_q    <= '0;
      complete_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_k_q    <= fill_k_d;
      used_q      <= used_d;
      placed_q    <= placed_d;
      complete_q  <= complete_d;
      out_valid_q <= out_valid_d;
    end
  end

  // alphabet tables: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (can_place) begin
      cipher_mem[placed_eff] <= place_idx;
      plain_mem[place_idx]   <= placed_eff;
    end
    if (text_pop) begin
      rd_q    <= (op_i.kind == OP_ENC) ? cipher_mem[op_i.idx] : plain_mem[op_i.idx];
      ch_q    <= op_i.ch;
      lower_q <= op_i.lower;
      hit_q   <= hit;
    end
  end

  // rebuild the letter with its case
  assign out_valid_o = out_valid_q;
  assign char_out_o  = hit_q ? ((lower_q ? CHAR_LO_A : CHAR_UP_A) + CHAR_W'(rd_q)) : ch_q;

  // placed count tracks the set of used letters
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(placed_q))
    else $error("placed count differs from used letters");

  // a complete alphabet holds every letter
  a_complete_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> (placed_q == LETTER_W'(NUM_LETTERS)) && (&used_q))
    else $error("alphabet marked complete but not full");

  // no item leaves the queue during the fill
  a_no_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filling |-> !pop_o)
    else $error("pop during fill");

  // the last fill step completes the alphabet
  a_fill_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filling && (fill_k_q == '0)) |=> (complete_q && (state_q == ST_RUN)))
    else $error("fill did not complete alphabet");

endmodule

### hdl/keyword_substitution_cipher_unit.sv
// Keyword substitution cipher unit, top level.
// Text words pass the queue, then the output register; one per cycle while out_stall_i is low and no fill runs.
// A keyword word needs no output slot; the last one starts the fill, which places the letters from Z down to A.
// Queue of 4 words lets the input keep flowing during a fill until it fills up.
// Reset clears the queue, the alphabet state and the output valid; tables hold garbage.
// Depends on kscu_pkg, kscu_front, kscu_fifo and kscu_back.
module keyword_substitution_cipher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kscu_pkg::MODE_W-1:0] mode_i,
  input  logic [kscu_pkg::CHAR_W-1:0] char_in_i,
  input  logic                        keyword_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kscu_pkg::CHAR_W-1:0] char_out_o
);
  import kscu_pkg::*;

  logic fifo_full;
  logic fifo_valid;
  logic push;
  logic pop;
  op_t  front_op;
  op_t  head_op;

  kscu_front u_front (
    .in_valid_i     (in_valid_i),
    .mode_i         (mode_i),
    .char_in_i      (char_in_i),
    .keyword_last_i (keyword_last_i),
    .fifo_full_i    (fifo_full),
    .in_stall_o     (in_stall_o),
    .push_o         (push),
    .op_o           (front_op)
  );

  kscu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .op_o    (head_op)
  );

  kscu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .op_i         (head_op),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_out_o   (char_out_o)
  );

endmodule

### tb/tb_keyword_substitution_cipher_unit.sv
// Self-checking testbench for keyword_substitution_cipher_unit: directed and random words.
// A built-in cipher predictor queues the expected text bytes. Needs kscu_pkg and the RTL.
`timescale 1ns / 1ps

module tb_keyword_substitution_cipher_unit;
  import kscu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i         = MODE_KEY;
  logic [CHAR_W-1:0]   char_in_i      = '0;
  logic                keyword_last_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [CHAR_W-1:0]   char_out_o;

  // predictor copy of the alphabet state
  logic [NUM_LETTERS-1:0] letter_used;
  logic [LETTER_W-1:0]    cipher_table [NUM_LETTERS];
  logic [LETTER_W-1:0]    plain_of_cipher [NUM_LETTERS];
  logic [LETTER_W-1:0]    letters_placed;
  logic                   alphabet_complete;

  logic [CHAR_W-1:0] expected_chars [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned alphabets_built = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  keyword_substitution_cipher_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .char_in_i     (char_in_i),
    .keyword_last_i(keyword_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_out_o    (char_out_o)
  );

  always #5 clk_i = ~clk_i;

  // place one letter in the next free alphabet slot unless already used or full
  function automatic void place_letter(input logic [LETTER_W-1:0] idx);
    if (idx >= NUM_LETTERS || letters_placed >= NUM_LETTERS) return;
    if (letter_used[idx]) return;
    letter_used[idx] = 1'b1;
    cipher_table[letters_placed] = idx;
    plain_of_cipher[idx] = letters_placed;
    letters_placed = letters_placed + 1'b1;
  endfunction

  // advance the predicted cipher state by one word; return 1 when a text byte comes out
  function automatic bit cipher_step(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                                     input logic l, output logic [CHAR_W-1:0] r);
    logic lo;
    logic is_letter;
    logic [LETTER_W-1:0] idx;
    lo = (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
    is_letter = lo || ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z));
    idx = lo ? LETTER_W'(c - CHAR_LO_A) : LETTER_W'(c - CHAR_UP_A);
    r = c;
    if (m == MODE_KEY) begin
      if (alphabet_complete) begin
        letter_used = '0;
        letters_placed = '0;
        alphabet_complete = 1'b0;
      end
      if (is_letter) place_letter(idx);
      if (l) begin
        for (int k = NUM_LETTERS - 1; k >= 0; k--) place_letter(LETTER_W'(k));
        alphabet_complete = 1'b1;
        alphabets_built++;
      end
      return 1'b0;
    end
    if (m == MODE_UNUSED) return 1'b0;
    if (is_letter) begin
      if (m == MODE_ENC && alphabet_complete) begin
        r = (lo ? CHAR_LO_A : CHAR_UP_A) + CHAR_W'(cipher_table[idx]);
      end else if (m == MODE_DEC && letter_used[idx]) begin
        r = (lo ? CHAR_LO_A : CHAR_UP_A) + CHAR_W'(plain_of_cipher[idx]);
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // hold one word on the input until accepted, after a random idle gap
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                           input logic l);
    logic [CHAR_W-1:0] r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    char_in_i      <= c;
    keyword_last_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    if (cipher_step(m, c, l, r)) expected_chars = {expected_chars, r};
    if (m != MODE_UNUSED) words_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] random_letter();
    logic [CHAR_W-1:0] base;
    base = $urandom_range(1) ? CHAR_LO_A : CHAR_UP_A;
    return base + CHAR_W'($urandom_range(NUM_LETTERS - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] keyword_byte();
    return ($urandom_range(99) < 85) ? random_letter() : CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [CHAR_W-1:0] text_byte();
    return ($urandom_range(99) < 80) ? random_letter() : CHAR_W'($urandom_range(255));
  endfunction

  // drive the receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each accepted result word with the oldest expected byte
  always @(posedge clk_i) begin
    logic [CHAR_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with nothing expected", char_out_o));
      end else begin
        want = expected_chars.pop_front();
        results_checked++;
        if (char_out_o !== want)
          report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h", char_out_o, want));
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // encrypt and decrypt with no alphabet yet, plus an ignored mode
  task automatic test_text_before_alphabet();
    send_word(MODE_ENC, "A", 1'b0);
    send_word(MODE_DEC, "q", 1'b0);
    send_word(MODE_UNUSED, "x", 1'b1);
  endtask

  // partial keyword with duplicates and a non-letter, then fill and text extremes
  task automatic test_keyword_build();
    send_word(MODE_KEY, "Q", 1'b0);
    send_word(MODE_KEY, "q", 1'b0);
    send_word(MODE_KEY, "3", 1'b0);
    send_word(MODE_DEC, "q", 1'b0);
    send_word(MODE_DEC, "B", 1'b0);
    send_word(MODE_KEY, "z", 1'b1);
    send_word(MODE_ENC, "A", 1'b0);
    send_word(MODE_DEC, "Z", 1'b0);
    send_word(MODE_ENC, "a", 1'b0);
    send_word(MODE_DEC, "z", 1'b0);
    send_word(MODE_ENC, 8'h00, 1'b0);
    send_word(MODE_DEC, 8'hFF, 1'b1);
    send_word(MODE_ENC, "@", 1'b1);
    send_word(MODE_DEC, "{", 1'b0);
  endtask

  // new keyword after completion that places no letter: alphabet runs Z down to A
  task automatic test_rekey_empty_keyword();
    send_word(MODE_KEY, " ", 1'b1);
    send_word(MODE_ENC, "M", 1'b0);
    send_word(MODE_DEC, "m", 1'b0);
  endtask

  // mostly keyword-then-text sequences, some full permutations, broken keys and noise
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned run_len;
    int unsigned j;
    logic [LETTER_W-1:0] perm [NUM_LETTERS];
    logic [LETTER_W-1:0] tmp;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        run_len = $urandom_range(10);
        repeat (run_len) send_word(MODE_KEY, keyword_byte(), 1'b0);
        send_word(MODE_KEY, keyword_byte(), 1'b1);
      end else if (pick < 86) begin
        // shuffled alphabet fills every slot before the last byte
        for (int k = 0; k < NUM_LETTERS; k++) perm[k] = LETTER_W'(k);
        for (int k = NUM_LETTERS - 1; k > 0; k--) begin
          j = $urandom_range(k);
          tmp = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        for (int k = 0; k < NUM_LETTERS; k++)
          send_word(MODE_KEY, ($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A) + CHAR_W'(perm[k]),
                    1'b0);
        send_word(MODE_KEY, keyword_byte(), 1'b1);
      end else if (pick < 93) begin
        // keyword left open: text sees a partial alphabet
        run_len = $urandom_range(5, 1);
        repeat (run_len) send_word(MODE_KEY, keyword_byte(), 1'b0);
      end else begin
        run_len = $urandom_range(8, 1);
        repeat (run_len)
          send_word(MODE_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                    1'($urandom_range(1)));
        continue;
      end
      run_len = $urandom_range(24, 1);
      repeat (run_len)
        send_word($urandom_range(1) ? MODE_ENC : MODE_DEC, text_byte(), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    letter_used = '0;
    letters_placed = '0;
    alphabet_complete = 1'b0;
    for (int k = 0; k < NUM_LETTERS; k++) begin
      cipher_table[k] = '0;
      plain_of_cipher[k] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 65;
    test_text_before_alphabet();
    test_keyword_build();
    test_rekey_empty_keyword();
    test_random_traffic(550);

    send_idle_pct = 65;
    recv_idle_pct = 26;
    test_random_traffic(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(550);

    // drain the remaining results, then leave room for stray ones
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words, completed %0d alphabets, checked %0d text bytes.",
             words_sent, alphabets_built, results_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### keyword_substitution_cipher_unit.f
hdl/kscu_pkg.sv
hdl/kscu_front.sv
hdl/kscu_fifo.sv
hdl/kscu_back.sv
hdl/keyword_substitution_cipher_unit.sv
tb/tb_keyword_substitution_cipher_unit.sv
